/* rtl/core/pagu_pkg.sv */
// Shared types, constants and helpers for the parabolic arc point generator.
`timescale 1ns / 1ps
`default_nettype none

package pagu_pkg;

   // Coordinate and segment widths, fixed by the interface
   localparam int COORD_W = 24;
   localparam int SEG_W   = 6;
   localparam int SQ_W    = 2 * COORD_W;

   // Segment count after reset
   localparam logic [SEG_W-1:0] SEG_COUNT_RESET = 6'd13;

   // Default depth of the command queue between front and back end
   localparam int CMD_QUEUE_DEPTH = 4;

   // Reciprocal table: ceil(2^RECIP_SHIFT / n) is exact for dividends below 2^COORD_W
   localparam int RECIP_SHIFT = COORD_W + SEG_W;
   localparam int RECIP_W     = RECIP_SHIFT + 1;

   // One input item
   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
   } req_type;

   // One result item
   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic [SEG_W-1:0]          point_index;
      logic                      last_point;
   } rsp_type;

   // Prepared arc, handed from the front end to the back end
   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic [COORD_W-1:0]        step_x;     // two's complement, modulo 2^COORD_W
      logic [COORD_W-1:0]        rise_mag;   // |end_y - start_y|
      logic                      rise_neg;
      logic [SQ_W-1:0]           run_sq;     // (end_x - start_x)^2
      logic                      run_zero;
      logic [SEG_W-1:0]          seg_count;  // never zero
   } cmd_type;

   // Magnitude of a one-bit-wider signed difference; fits COORD_W bits here
   function automatic logic [COORD_W-1:0] mag_of(input logic signed [COORD_W:0] v);
      logic [COORD_W:0] m;
      m = v[COORD_W] ? (COORD_W+1)'(-v) : (COORD_W+1)'(v);
      return m[COORD_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/core/pagu_front.sv */
// Front end: input transfer, segment count register, run/rise and step preparation.
`timescale 1ns / 1ps
`default_nettype none

module pagu_front
   import pagu_pkg::*;
#(
   parameter int QUEUE_DEPTH = CMD_QUEUE_DEPTH
)(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire req_type          req_data,
   input  wire logic             csr_write_enable,
   input  wire logic [SEG_W-1:0] csr_write_data,
   input  wire logic             cmd_pop,
   output logic                  cmd_push,
   output cmd_type               cmd_data
);

   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

   // Reciprocal table, built at elaboration
   logic [RECIP_W-1:0] recip_table [2**SEG_W];
   for (genvar g = 0; g < 2**SEG_W; g++) begin : g_recip
      localparam longint G_DIV = (g == 0) ? 1 : g;
      localparam longint RC    = ((longint'(1) << RECIP_SHIFT) + G_DIV - 1) / G_DIV;
      assign recip_table[g] = RECIP_W'(RC);
   end

   logic             accept;
   logic [SEG_W-1:0] seg_count_ff;
   logic [OCC_W-1:0] occ_ff, occ_in;

   // stage A
   logic             a_valid_ff;
   req_type          a_req_ff;
   logic [SEG_W-1:0] a_seg_ff, a_seg_in;

   // stage B
   logic                  b_valid_ff;
   req_type               b_req_ff;
   logic [SEG_W-1:0]      b_seg_ff;
   logic [COORD_W-1:0]    b_run_mag_ff, b_rise_mag_ff;
   logic                  b_run_neg_ff, b_rise_neg_ff;
   logic [RECIP_W-1:0]    b_recip_ff;
   logic signed [COORD_W:0] run_full, rise_full;

   // stage C
   logic                          c_valid_ff;
   req_type                       c_req_ff;
   logic [SEG_W-1:0]              c_seg_ff;
   logic [COORD_W-1:0]            c_step_mag_ff, c_rise_mag_ff;
   logic                          c_run_neg_ff, c_rise_neg_ff, c_run_zero_ff;
   logic [SQ_W-1:0]               c_run_sq_ff;
   logic [COORD_W+RECIP_W-1:0]    step_prod;

   // Credit count covers items in stages A to C plus those held in the queue
   assign accept   = req_push && !req_full;
   assign req_full = (occ_ff == OCC_W'(QUEUE_DEPTH));
   assign occ_in   = occ_ff + OCC_W'(accept) - OCC_W'(cmd_pop);

   // A zero segment count is taken as one segment
   assign a_seg_in = (seg_count_ff == '0) ? SEG_W'(1) : seg_count_ff;

   assign run_full  = $signed({a_req_ff.end_x[COORD_W-1], a_req_ff.end_x})
                    - $signed({a_req_ff.start_x[COORD_W-1], a_req_ff.start_x});
   assign rise_full = $signed({a_req_ff.end_y[COORD_W-1], a_req_ff.end_y})
                    - $signed({a_req_ff.start_y[COORD_W-1], a_req_ff.start_y});

   // |run| / n through the reciprocal, exact truncation
   assign step_prod = (COORD_W+RECIP_W)'(b_run_mag_ff) * (COORD_W+RECIP_W)'(b_recip_ff);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         seg_count_ff <= SEG_COUNT_RESET;
         occ_ff       <= '0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            seg_count_ff <= csr_write_data;
         end
         occ_ff     <= occ_in;
         a_valid_ff <= accept;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   // Payload stages, qualified by the valid bits
   always_ff @(posedge clock) begin
      a_req_ff      <= req_data;
      a_seg_ff      <= a_seg_in;

      b_req_ff      <= a_req_ff;
      b_seg_ff      <= a_seg_ff;
      b_run_mag_ff  <= mag_of(run_full);
      b_run_neg_ff  <= run_full[COORD_W];
      b_rise_mag_ff <= mag_of(rise_full);
      b_rise_neg_ff <= rise_full[COORD_W];
      b_recip_ff    <= recip_table[a_seg_ff];

      c_req_ff      <= b_req_ff;
      c_seg_ff      <= b_seg_ff;
      c_step_mag_ff <= step_prod[RECIP_SHIFT +: COORD_W];
      c_run_neg_ff  <= b_run_neg_ff;
      c_run_zero_ff <= (b_run_mag_ff == '0);
      c_run_sq_ff   <= SQ_W'(b_run_mag_ff) * SQ_W'(b_run_mag_ff);
      c_rise_mag_ff <= b_rise_mag_ff;
      c_rise_neg_ff <= b_rise_neg_ff;
   end

   // Prepared arc to the queue
   assign cmd_push = c_valid_ff;
   always_comb begin
      cmd_data.start_x   = c_req_ff.start_x;
      cmd_data.start_y   = c_req_ff.start_y;
      cmd_data.end_x     = c_req_ff.end_x;
      cmd_data.end_y     = c_req_ff.end_y;
      cmd_data.step_x    = c_run_neg_ff ? ((~c_step_mag_ff) + COORD_W'(1)) : c_step_mag_ff;
      cmd_data.rise_mag  = c_rise_mag_ff;
      cmd_data.rise_neg  = c_rise_neg_ff;
      cmd_data.run_sq    = c_run_sq_ff;
      cmd_data.run_zero  = c_run_zero_ff;
      cmd_data.seg_count = c_seg_ff;
   end

endmodule

`default_nettype wire

/* rtl/core/pagu_cmd_queue.sv */
// Short queue of prepared arcs between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module pagu_cmd_queue
   import pagu_pkg::*;
#(
   parameter int DEPTH = CMD_QUEUE_DEPTH
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_data,
   input  wire logic    pop,
   output logic         empty,
   output cmd_type      head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   // Pointers and fill level; the front end's credits keep pushes within depth
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + CNT_W'(push) - CNT_W'(pop);
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

endmodule

`default_nettype wire

/* rtl/core/pagu_back.sv */
// Back end: point sequencer, squared-distance products, pipelined divider, output register.
`timescale 1ns / 1ps
`default_nettype none

module pagu_back
   import pagu_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd_data,
   output logic         cmd_pop,
   output logic         rsp_empty,
   input  wire logic    rsp_pop,
   output rsp_type      rsp_data
);

   localparam int DIV_STEPS = COORD_W;
   localparam int NUM_W     = SQ_W + COORD_W;
   localparam logic signed [COORD_W+1:0] Y_HI = (COORD_W+2)'(2**(COORD_W-1) - 1);
   localparam logic signed [COORD_W+1:0] Y_LO = (COORD_W+2)'(-(2**(COORD_W-1)));

   typedef struct packed {
      logic [COORD_W-1:0]        x;
      logic signed [COORD_W-1:0] base_y;
      logic                      rise_neg;
      logic                      bypass;   // y is base_y as it stands
      logic [SEG_W-1:0]          idx;
      logic                      last;
   } side_type;

   typedef struct packed {
      logic [SQ_W-1:0]    rem;
      logic [COORD_W-1:0] lowq;      // numerator bits out at the top, quotient bits in below
      logic [SQ_W-1:0]    divisor;
      side_type           side;
   } div_type;

   logic advance;
   logic out_valid_ff;
   rsp_type out_data_ff;

   // whole pipeline moves when the output register is free or being taken
   assign advance = !out_valid_ff || rsp_pop;

   // Point sequencer
   logic [SEG_W-1:0]        k_ff, k_in;
   logic [COORD_W-1:0]      cur_x_ff, cur_x_in, issue_x;
   logic                    issue, first, final_pt;
   logic signed [COORD_W:0] gap;

   assign issue    = cmd_valid && advance;
   assign first    = (k_ff == '0);
   assign final_pt = (k_ff == cmd_data.seg_count);
   assign issue_x  = first ? cmd_data.start_x : cur_x_ff;
   assign gap      = $signed({issue_x[COORD_W-1], issue_x})
                   - $signed({cmd_data.end_x[COORD_W-1], cmd_data.end_x});
   assign cmd_pop  = issue && final_pt;
   assign k_in     = !issue ? k_ff : (final_pt ? '0 : k_ff + 1'b1);
   assign cur_x_in = issue ? (issue_x + cmd_data.step_x) : cur_x_ff;

   // Stage registers
   logic               s0_valid_ff, s1_valid_ff, s2_valid_ff;
   side_type           s0_side_ff, s1_side_ff, s2_side_ff, s0_side_in;
   logic [COORD_W-1:0] s0_d_ff, s0_m_ff, s1_m_ff;
   logic [SQ_W-1:0]    s0_b_ff, s1_b_ff, s2_b_ff;
   logic [SQ_W-1:0]    s1_d2_ff, s2_p_hi_ff, s2_p_lo_ff;
   logic [NUM_W-1:0]   num;
   logic               div_valid_ff [DIV_STEPS+1];
   div_type            div_ff       [DIV_STEPS+1];
   div_type            div_next     [DIV_STEPS];

   always_comb begin
      s0_side_in.x        = issue_x;
      s0_side_in.base_y   = first ? cmd_data.start_y : cmd_data.end_y;
      s0_side_in.rise_neg = cmd_data.rise_neg;
      s0_side_in.bypass   = first || cmd_data.run_zero;
      s0_side_in.idx      = k_ff;
      s0_side_in.last     = final_pt;
   end

   // rise * d^2 as two partial products, summed into the dividend
   assign num = {s2_p_hi_ff, {COORD_W{1'b0}}} + NUM_W'(s2_p_lo_ff);

   // Restoring divider, one quotient bit per stage
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      logic [SQ_W:0] shifted;
      logic          fits;
      div_type       nxt;
      assign shifted = {div_ff[j].rem, div_ff[j].lowq[COORD_W-1]};
      assign fits    = (shifted >= {1'b0, div_ff[j].divisor});
      always_comb begin
         nxt      = div_ff[j];
         nxt.rem  = fits ? SQ_W'(shifted - {1'b0, div_ff[j].divisor}) : shifted[SQ_W-1:0];
         nxt.lowq = {div_ff[j].lowq[COORD_W-2:0], fits};
      end
      assign div_next[j] = nxt;
   end

   // Final y: add or take off the quotient, then clamp
   div_type                 tail;
   logic signed [COORD_W+1:0] base_w, quot_w, y_w;
   logic signed [COORD_W-1:0] y_sat;
   rsp_type                 out_data_in;

   assign tail   = div_ff[DIV_STEPS];
   assign base_w = $signed({{2{tail.side.base_y[COORD_W-1]}}, tail.side.base_y});
   assign quot_w = $signed({2'b00, tail.lowq});
   assign y_w    = tail.side.rise_neg ? (base_w + quot_w) : (base_w - quot_w);

   always_comb begin
      priority if (y_w > Y_HI) begin
         y_sat = Y_HI[COORD_W-1:0];
      end else if (y_w < Y_LO) begin
         y_sat = Y_LO[COORD_W-1:0];
      end else begin
         y_sat = y_w[COORD_W-1:0];
      end
      out_data_in.point_x     = tail.side.x;
      out_data_in.point_y     = tail.side.bypass ? tail.side.base_y : y_sat;
      out_data_in.point_index = tail.side.idx;
      out_data_in.last_point  = tail.side.last;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         for (int j = 0; j <= DIV_STEPS; j++) begin
            div_valid_ff[j] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else begin
         k_ff <= k_in;
         if (advance) begin
            s0_valid_ff     <= cmd_valid;
            s1_valid_ff     <= s0_valid_ff;
            s2_valid_ff     <= s1_valid_ff;
            div_valid_ff[0] <= s2_valid_ff;
            for (int j = 0; j < DIV_STEPS; j++) begin
               div_valid_ff[j+1] <= div_valid_ff[j];
            end
            out_valid_ff    <= div_valid_ff[DIV_STEPS];
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in;
      if (advance) begin
         s0_side_ff <= s0_side_in;
         s0_d_ff    <= mag_of(gap);
         s0_m_ff    <= cmd_data.rise_mag;
         s0_b_ff    <= cmd_data.run_sq;

         s1_side_ff <= s0_side_ff;
         s1_d2_ff   <= SQ_W'(s0_d_ff) * SQ_W'(s0_d_ff);
         s1_m_ff    <= s0_m_ff;
         s1_b_ff    <= s0_b_ff;

         s2_side_ff <= s1_side_ff;
         s2_p_hi_ff <= SQ_W'(s1_m_ff) * SQ_W'(s1_d2_ff[SQ_W-1:COORD_W]);
         s2_p_lo_ff <= SQ_W'(s1_m_ff) * SQ_W'(s1_d2_ff[COORD_W-1:0]);
         s2_b_ff    <= s1_b_ff;

         div_ff[0].rem     <= num[NUM_W-1:COORD_W];
         div_ff[0].lowq    <= num[COORD_W-1:0];
         div_ff[0].divisor <= s2_b_ff;
         div_ff[0].side    <= s2_side_ff;
         for (int j = 0; j < DIV_STEPS; j++) begin
            div_ff[j+1] <= div_next[j];
         end

         out_data_ff <= out_data_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

/* rtl/core/parabolic_arc_point_generator_unit.sv */
// Top level of the parabolic arc point generator.
`timescale 1ns / 1ps
`default_nettype none

// Each input transfer carries a start and an end point in signed Q15.8; the unit returns
// segment_count+1 points along a parabola with its vertex at the end point, point 0 being
// the start point and the final one flagged by last_point. Points leave at one per cycle
// while the result side keeps popping them (rsp_pop); segment_count resets to 13. The
// back-end sequencer issues one point per cycle, while an arc is queued and the pipeline
// advances, into a pipeline of 29 registers (distance, square, two partial products,
// dividend sum, 24 divider stages, output register). The front end prepares run, rise, step
// and run squared in three stages and keeps up to QUEUE_DEPTH arcs ahead of the back end, so
// new inputs are taken while earlier arcs are still being emitted.
// The segment count is written through csr_write_enable/csr_write_data while idle;
// a value of 0 acts as 1.
module parabolic_arc_point_generator_unit
   import pagu_pkg::*;
#(
   parameter int QUEUE_DEPTH = CMD_QUEUE_DEPTH
)(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire req_type          req_data,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output rsp_type               rsp_data,
   input  wire logic             csr_write_enable,
   input  wire logic [SEG_W-1:0] csr_write_data
);

   logic    cmd_push, cmd_pop, cmd_empty;
   cmd_type cmd_in, cmd_head;

   // Accept and prepare
   pagu_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd_pop          (cmd_pop),
      .cmd_push         (cmd_push),
      .cmd_data         (cmd_in)
   );

   // Decoupling queue
   pagu_cmd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .head      (cmd_head)
   );

   // Emit points
   pagu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!cmd_empty),
      .cmd_data  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* sim/parabolic_arc_point_generator_unit_checker.sv */
// Checker for the parabolic arc point generator: predicts every arc point and compares.
`timescale 1ns / 1ps

module parabolic_arc_point_generator_unit_checker
   import pagu_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   input  wire logic             req_full,
   input  wire req_type          req_data,
   input  wire logic             rsp_empty,
   input  wire logic             rsp_pop,
   input  wire rsp_type          rsp_data,
   input  wire logic             csr_write_enable,
   input  wire logic [SEG_W-1:0] csr_write_data,
   output int                    fail_count,
   output int                    points_outstanding
);

   localparam longint COORD_MAX = 64'sd8388607;
   localparam longint COORD_MIN = -64'sd8388608;

   // Own copy of the segment count register
   logic [SEG_W-1:0] seg_count_copy;
   // Points predicted but not yet seen on the result side
   rsp_type          pending_points[$];
   rsp_type          want;

   initial begin
      fail_count         = 0;
      points_outstanding = 0;
      seg_count_copy     = SEG_COUNT_RESET;
   end

   // Queue up every point of one arc, start point first
   task automatic plot_arc(input req_type arc);
      longint       sx, sy, ex, ey, run, rise, step, cur, y, n;
      logic [63:0]  gap_mag, run_mag, rise_mag;
      logic [127:0] num, den, quot;
      rsp_type      pt;
      int           k;
      n    = (seg_count_copy == '0) ? 64'sd1 : longint'(seg_count_copy);
      sx   = arc.start_x;
      sy   = arc.start_y;
      ex   = arc.end_x;
      ey   = arc.end_y;
      run  = ex - sx;
      rise = ey - sy;
      // truncates toward zero
      step = run / n;
      cur  = sx;
      pt.point_x     = arc.start_x;
      pt.point_y     = arc.start_y;
      pt.point_index = '0;
      pt.last_point  = 1'b0;
      pending_points.push_back(pt);
      for (k = 1; k <= n; k++) begin
         cur = cur + step;
         if (run == 0) begin
            // vertical arc: everything after the start sits on the vertex height
            y = ey;
         end else begin
            gap_mag  = (cur < ex) ? ex - cur : cur - ex;
            run_mag  = (run < 0) ? -run : run;
            rise_mag = (rise < 0) ? -rise : rise;
            num      = {64'd0, rise_mag} * {64'd0, gap_mag} * {64'd0, gap_mag};
            den      = {64'd0, run_mag} * {64'd0, run_mag};
            quot     = num / den;
            y = (rise < 0) ? ey + longint'(quot[63:0]) : ey - longint'(quot[63:0]);
         end
         // clamp to the 24-bit signed range
         if (y > COORD_MAX) y = COORD_MAX;
         if (y < COORD_MIN) y = COORD_MIN;
         pt.point_x     = cur[COORD_W-1:0];
         pt.point_y     = y[COORD_W-1:0];
         pt.point_index = k[SEG_W-1:0];
         pt.last_point  = (k == n);
         pending_points.push_back(pt);
      end
   endtask

   // Watch both channels and the register port on each rising edge
   always @(posedge clock) begin
      if (reset) begin
         seg_count_copy = SEG_COUNT_RESET;
         pending_points.delete();
      end else begin
         if (csr_write_enable) seg_count_copy = csr_write_data;
         if (req_push && !req_full) plot_arc(req_data);
         if (rsp_pop && !rsp_empty) begin
            if (pending_points.size() == 0) begin
               $display("%0t: unexpected point, got x %0d y %0d index %0d last %0b",
                        $time, rsp_data.point_x, rsp_data.point_y,
                        rsp_data.point_index, rsp_data.last_point);
               fail_count++;
            end else begin
               want = pending_points.pop_front();
               if (want.point_x !== rsp_data.point_x) begin
                  $display("%0t: point_x mismatch, expected %0d, got %0d",
                           $time, want.point_x, rsp_data.point_x);
                  fail_count++;
               end
               if (want.point_y !== rsp_data.point_y) begin
                  $display("%0t: point_y mismatch, expected %0d, got %0d",
                           $time, want.point_y, rsp_data.point_y);
                  fail_count++;
               end
               if (want.point_index !== rsp_data.point_index) begin
                  $display("%0t: point_index mismatch, expected %0d, got %0d",
                           $time, want.point_index, rsp_data.point_index);
                  fail_count++;
               end
               if (want.last_point !== rsp_data.last_point) begin
                  $display("%0t: last_point mismatch, expected %0b, got %0b",
                           $time, want.last_point, rsp_data.last_point);
                  fail_count++;
               end
            end
         end
      end
      points_outstanding <= pending_points.size();
   end

endmodule

/* sim/parabolic_arc_point_generator_unit_tb.sv */
// Testbench top for the parabolic arc point generator: stimulus, pacing and verdict.
`timescale 1ns / 1ps

module parabolic_arc_point_generator_unit_tb;
   import pagu_pkg::*;

   localparam int     DRAIN_CYCLES = 40;
   localparam longint CYCLE_LIMIT  = 2000000;
   localparam logic signed [COORD_W-1:0] C_MAX = 24'sh7FFFFF;
   localparam logic signed [COORD_W-1:0] C_MIN = 24'sh800000;

   logic             clock;
   logic             reset;
   logic             req_push;
   logic             req_full;
   req_type          req_data;
   logic             rsp_empty;
   logic             rsp_pop;
   rsp_type          rsp_data;
   logic             csr_write_enable;
   logic [SEG_W-1:0] csr_write_data;
   int               fail_count;
   int               points_outstanding;
   longint           cycle_count;
   logic             calm;

   // Segment counts per random phase and the arcs sent in each
   int seg_plan[10]   = '{0, 1, 63, 2, 31, 7, 4, 13, 63, 9};
   int arcs_plan[10]  = '{20, 20, 4, 20, 5, 20, 20, 20, 3, 18};

   parabolic_arc_point_generator_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data         (req_data),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   parabolic_arc_point_generator_unit_checker checker_i (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_data           (req_data),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_data           (rsp_data),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .fail_count         (fail_count),
      .points_outstanding (points_outstanding)
   );

   // 4 ns clock
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Run-away guard
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL parabolic_arc_point_generator_unit");
         $finish;
      end
   end

   // Idle length: mostly none or short, now and then long; none at all in calm phases
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic req_type arc(input logic signed [COORD_W-1:0] sx,
                                   input logic signed [COORD_W-1:0] sy,
                                   input logic signed [COORD_W-1:0] ex,
                                   input logic signed [COORD_W-1:0] ey);
      req_type a;
      a.start_x = sx;
      a.start_y = sy;
      a.end_x   = ex;
      a.end_y   = ey;
      return a;
   endfunction

   function automatic logic signed [COORD_W-1:0] pick_extreme();
      case ($urandom_range(0, 3))
         0:       return C_MAX;
         1:       return C_MIN;
         2:       return '0;
         default: return '1;
      endcase
   endfunction

   // Random arc: mostly full range, plus short runs, vertical, flat and extreme ones
   function automatic req_type random_arc();
      req_type a;
      int      r;
      a = req_type'({$urandom(), $urandom(), $urandom()});
      r = $urandom_range(0, 9);
      if (r == 5 || r == 6) begin
         a.end_x = a.start_x + COORD_W'($signed($urandom_range(0, 400)) - 200);
      end else if (r == 7) begin
         a.end_x = a.start_x;
      end else if (r == 8) begin
         a = arc(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
      end else if (r == 9) begin
         a.end_y = a.start_y;
      end
      return a;
   endfunction

   // One input transfer after a random idle stretch; push stays high across back-to-back arcs
   task automatic send_arc(input req_type a);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_push = 1'b0;
      end
      @(negedge clock);
      req_push = 1'b1;
      req_data = a;
      do @(posedge clock); while (req_full);
   endtask

   // Let every predicted point come out, then write the segment count
   task automatic set_segments(input int value);
      @(negedge clock);
      req_push = 1'b0;
      while (points_outstanding != 0) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = SEG_W'(value);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // Result side: pop with random stalls
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_pop    = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_pop = 1'b0;
            stall_left--;
         end else begin
            rsp_pop    = 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   // Stimulus and verdict
   initial begin
      int p, i;
      reset            = 1'b1;
      req_push         = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      calm             = 1'b0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Directed arcs at the reset segment count
      send_arc(arc('0, '0, '0, '0));
      send_arc(arc(24'sd100, -24'sd5000, 24'sd100, 24'sd7000));
      send_arc(arc(C_MIN, C_MAX, C_MIN, C_MIN));
      send_arc(arc(-24'sd3000, 24'sd2500, 24'sd9000, 24'sd2500));
      send_arc(arc(C_MIN, C_MAX, C_MAX, C_MIN));
      send_arc(arc(C_MAX, C_MIN, C_MIN, C_MAX));
      send_arc(arc('0, '0, 24'sd12, 24'sd1000));
      send_arc(arc(24'sd13, 24'sd500, '0, -24'sd500));
      send_arc(arc('1, '1, '0, '0));
      send_arc(arc(C_MAX, C_MAX, C_MAX, C_MAX));
      send_arc(arc(C_MIN, C_MIN, C_MIN, C_MIN));
      send_arc(arc(24'sh000080, 24'sh000040, 24'sh001280, 24'shFFF0C0));
      send_arc(arc(C_MIN, '0, '0, C_MAX));
      send_arc(arc(C_MAX, C_MAX, C_MIN, C_MAX));
      send_arc(arc(C_MAX, '0, '0, C_MIN));
      send_arc(arc(24'sh555555, 24'shAAAAAA, 24'shAAAAAA, 24'sh555555));
      send_arc(random_arc());

      // Random phases, each at its own segment count
      for (p = 0; p < 10; p++) begin
         set_segments(seg_plan[p]);
         calm = ($urandom_range(0, 3) == 0);
         for (i = 0; i < arcs_plan[p]; i++) send_arc(random_arc());
      end

      // Drain
      @(negedge clock);
      req_push = 1'b0;
      calm     = 1'b0;
      while (points_outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && points_outstanding == 0) begin
         $display("PASS parabolic_arc_point_generator_unit");
      end else begin
         $display("FAIL parabolic_arc_point_generator_unit");
      end
      $finish;
   end

endmodule

/* parabolic_arc_point_generator_unit.f */
rtl/core/pagu_pkg.sv
rtl/core/pagu_front.sv
rtl/core/pagu_cmd_queue.sv
rtl/core/pagu_back.sv
rtl/core/parabolic_arc_point_generator_unit.sv
sim/parabolic_arc_point_generator_unit_checker.sv
sim/parabolic_arc_point_generator_unit_tb.sv
